// File: rtl/core/chp_pkg.sv
package chp_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;

    localparam int MAG_W    = 16;
    localparam int MAG_EW   = MAG_W + 1;
    localparam int VEC_SHIFT = 14;
    localparam int XW       = 34;
    localparam int ZW       = 26;
    localparam int FINE_SHIFT = 10;
    localparam int BASE_W   = ZW - FINE_SHIFT;
    localparam int CORR_W   = 16;
    localparam int SUM_W    = 19;
    localparam int ACC_W    = 17;
    localparam int HEAD_W   = 15;

    localparam int FULL_TURN      = 23040;
    localparam int HALF_TURN_FINE = 180 * 65536;
    localparam int ROUND_HALF     = 512;

    typedef logic signed [XW-1:0]     vec_t;
    typedef logic signed [ZW-1:0]     ang_t;
    typedef logic signed [BASE_W-1:0] base_t;

    typedef struct packed {
        logic zero;
        vec_t x;
        vec_t y;
        ang_t z;
    } cordic_t;

    // atan(2^-i) in 2^-16 degree
    function automatic ang_t atan_fine(input int i);
        ang_t v;
        case (i)
            0:       v = ZW'(2949120);
            1:       v = ZW'(1740967);
            2:       v = ZW'(919879);
            3:       v = ZW'(466945);
            4:       v = ZW'(234379);
            5:       v = ZW'(117304);
            6:       v = ZW'(58666);
            7:       v = ZW'(29335);
            8:       v = ZW'(14668);
            9:       v = ZW'(7334);
            10:      v = ZW'(3667);
            11:      v = ZW'(1833);
            12:      v = ZW'(917);
            13:      v = ZW'(458);
            14:      v = ZW'(229);
            15:      v = ZW'(115);
            16:      v = ZW'(57);
            17:      v = ZW'(29);
            18:      v = ZW'(14);
            19:      v = ZW'(7);
            20:      v = ZW'(4);
            21:      v = ZW'(2);
            22:      v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/compass_heading_from_magnetometer_core.sv
// channel   handshake          payload
// s_        s_valid / s_ready  s_mag_x, s_mag_y, s_mag_z (16 bit signed)
// m_        m_valid / m_ready  m_heading (15 bit, 1/64 degree, 0..23039)
// cfg       cfg_we             cfg_wdata (heading correction, 16 bit signed)
//
// one sample per cycle while the output is not stalled; pipeline stages:
// one prerotation stage, one stage per cordic iteration, four rounding/wrap stages
// the whole pipeline advances when the output register is empty or taken
// a one-entry input skid register keeps s_ready off the m_ready path
// synchronous active-low reset clears valid bits and sets the correction to 0
module compass_heading_from_magnetometer_core
    import chp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [MAG_W-1:0]  s_mag_x,
    input  logic signed [MAG_W-1:0]  s_mag_y,
    input  logic signed [MAG_W-1:0]  s_mag_z,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [HEAD_W-1:0]        m_heading,
    input  logic                     cfg_we,
    input  logic signed [CORR_W-1:0] cfg_wdata
);

    logic                     en;
    logic                     skid_valid_reg;
    logic                     skid_valid_next;
    logic signed [MAG_W-1:0]  skid_x_reg;
    logic signed [MAG_W-1:0]  skid_y_reg;
    logic signed [MAG_W-1:0]  skid_z_reg;
    logic                     src_valid;
    logic signed [MAG_W-1:0]  src_x;
    logic signed [MAG_W-1:0]  src_y;
    logic signed [MAG_W-1:0]  src_z;
    logic signed [CORR_W-1:0] corr_reg;
    logic                     pre_valid;
    cordic_t                  pre_data;
    logic                     cor_valid;
    cordic_t                  cor_data;

    assign en      = !m_valid || m_ready;
    assign s_ready = !skid_valid_reg;

    always_comb begin
        src_valid = skid_valid_reg || s_valid;
        src_x     = skid_valid_reg ? skid_x_reg : s_mag_x;
        src_y     = skid_valid_reg ? skid_y_reg : s_mag_y;
        src_z     = skid_valid_reg ? skid_z_reg : s_mag_z;

        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg && en) begin
            skid_valid_next = 1'b0;
        end else if (s_valid && s_ready && !en) begin
            // transaction taken while the pipeline is held
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
            corr_reg       <= '0;
        end else begin
            skid_valid_reg <= skid_valid_next;
            if (cfg_we) begin
                corr_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready && !en) begin
            skid_x_reg <= s_mag_x;
            skid_y_reg <= s_mag_y;
            skid_z_reg <= s_mag_z;
        end
    end

    chp_prerot u_prerot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (src_valid),
        .mag_x     (src_x),
        .mag_y     (src_y),
        .mag_z     (src_z),
        .out_valid (pre_valid),
        .out_data  (pre_data)
    );

    chp_cordic u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (pre_valid),
        .in_data   (pre_data),
        .out_valid (cor_valid),
        .out_data  (cor_data)
    );

    chp_heading u_heading (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (cor_valid),
        .in_data    (cor_data),
        .correction (corr_reg),
        .out_valid  (m_valid),
        .heading    (m_heading)
    );

endmodule

// File: rtl/core/chp_prerot.sv
module chp_prerot
    import chp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [MAG_W-1:0] mag_x,
    input  logic signed [MAG_W-1:0] mag_y,
    input  logic signed [MAG_W-1:0] mag_z,
    output logic                    out_valid,
    output cordic_t                 out_data
);

    logic                     valid_reg;
    cordic_t                  data_reg;
    cordic_t                  data_next;
    logic signed [MAG_EW-1:0] mx;
    logic signed [MAG_EW-1:0] my;
    logic signed [MAG_EW-1:0] num;
    logic signed [MAG_EW-1:0] den;
    vec_t                     x0;
    vec_t                     y0;

    always_comb begin
        mx = {mag_x[MAG_W-1], mag_x};
        my = {mag_y[MAG_W-1], mag_y};
        // z sign picks the sense of both axes
        if (!mag_z[MAG_W-1]) begin
            num = -mx;
            den = my;
        end else begin
            num = mx;
            den = -my;
        end
        x0 = {{(XW-MAG_EW){den[MAG_EW-1]}}, den} <<< VEC_SHIFT;
        y0 = {{(XW-MAG_EW){num[MAG_EW-1]}}, num} <<< VEC_SHIFT;

        data_next.zero = (num == '0) && (den == '0);
        data_next.x    = x0;
        data_next.y    = y0;
        data_next.z    = '0;
        // left half plane: turn by 180 degrees first
        if (den[MAG_EW-1]) begin
            data_next.x = -x0;
            data_next.y = -y0;
            data_next.z = num[MAG_EW-1] ? -ang_t'(HALF_TURN_FINE) : ang_t'(HALF_TURN_FINE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/core/chp_cordic.sv
module chp_cordic
    import chp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  logic    in_valid,
    input  cordic_t in_data,
    output logic    out_valid,
    output cordic_t out_data
);

    logic    valid_reg [CORDIC_STEPS];
    cordic_t st_reg    [CORDIC_STEPS];
    cordic_t st_next   [CORDIC_STEPS];
    cordic_t st_in     [CORDIC_STEPS];
    logic    v_in      [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        if (i == 0) begin : g_first
            assign st_in[i] = in_data;
            assign v_in[i]  = in_valid;
        end else begin : g_rest
            assign st_in[i] = st_reg[i-1];
            assign v_in[i]  = valid_reg[i-1];
        end

        always_comb begin
            st_next[i] = st_in[i];
            if (i < TABLE_LEN) begin
                // rotate toward the x axis, shift is fixed per stage
                if (!st_in[i].y[XW-1]) begin
                    st_next[i].x = st_in[i].x + (st_in[i].y >>> i);
                    st_next[i].y = st_in[i].y - (st_in[i].x >>> i);
                    st_next[i].z = st_in[i].z + atan_fine(i);
                end else begin
                    st_next[i].x = st_in[i].x - (st_in[i].y >>> i);
                    st_next[i].y = st_in[i].y + (st_in[i].x >>> i);
                    st_next[i].z = st_in[i].z - atan_fine(i);
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[i] <= 1'b0;
            end else if (en) begin
                valid_reg[i] <= v_in[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS-1];
    assign out_data  = st_reg[CORDIC_STEPS-1];

endmodule

// File: rtl/core/chp_heading.sv
module chp_heading
    import chp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  cordic_t                  in_data,
    input  logic signed [CORR_W-1:0] correction,
    output logic                     out_valid,
    output logic [HEAD_W-1:0]        heading
);

    localparam logic signed [SUM_W-1:0] WRAP_BIAS = SUM_W'(3 * FULL_TURN);
    localparam logic [ACC_W-1:0] TURN1 = ACC_W'(FULL_TURN);
    localparam logic [ACC_W-1:0] TURN2 = ACC_W'(2 * FULL_TURN);
    localparam logic [ACC_W-1:0] TURN4 = ACC_W'(4 * FULL_TURN);

    logic [3:0]               valid_reg;
    base_t                    base_reg;
    base_t                    base_next;
    ang_t                     z_round;
    logic [ACC_W-1:0]         sum_reg;
    logic [ACC_W-1:0]         sum_next;
    logic signed [SUM_W-1:0]  sum_wide;
    logic [ACC_W-1:0]         part_reg;
    logic [ACC_W-1:0]         part_next;
    logic [ACC_W-1:0]         part_a;
    logic [ACC_W-1:0]         fin_a;
    logic [HEAD_W-1:0]        heading_reg;
    logic [HEAD_W-1:0]        heading_next;

    always_comb begin
        // round half up to 1/64 degree, zero vector gives 0
        z_round   = in_data.z + ang_t'(ROUND_HALF);
        base_next = in_data.zero ? '0 : BASE_W'(z_round >>> FINE_SHIFT);

        // biased so the sum is never negative
        sum_wide = {{(SUM_W-CORR_W){correction[CORR_W-1]}}, correction}
                 - {{(SUM_W-BASE_W){base_reg[BASE_W-1]}}, base_reg}
                 + WRAP_BIAS;
        sum_next = sum_wide[ACC_W-1:0];

        part_a    = (sum_reg >= TURN4) ? sum_reg - TURN4 : sum_reg;
        part_next = (part_a >= TURN2) ? part_a - TURN2 : part_a;

        fin_a        = (part_reg >= TURN1) ? part_reg - TURN1 : part_reg;
        heading_next = fin_a[HEAD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            base_reg    <= base_next;
            sum_reg     <= sum_next;
            part_reg    <= part_next;
            heading_reg <= heading_next;
        end
    end

    assign out_valid = valid_reg[3];
    assign heading   = heading_reg;

endmodule

// File: rtl/core/chp_checker.sv
module chp_checker
    import chp_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [HEAD_W-1:0] m_heading
);

    // a held result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_heading))
        else $error("result changed while stalled");

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_heading < HEAD_W'(FULL_TURN))
        else $error("heading out of range");

    // input side only backs up behind a stalled result
    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid && m_valid && !m_ready))
        else $error("s_ready dropped without an output stall");

    a_skid_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input held with no result pending");

endmodule

bind compass_heading_from_magnetometer_core chp_checker u_chp_checker (.*);
